// ===== rtl/tcf_pkg.sv =====
`default_nettype none

package tcf_pkg;

  // Vectoring steps, capped at the arctangent table length
  localparam int CordicSteps = 16;
  localparam int AtanLen     = 24;
  localparam int NumSteps    = (CordicSteps < AtanLen) ? CordicSteps : AtanLen;
  localparam int StepW       = $clog2(AtanLen);

  // Field widths
  localparam int InW     = 16;
  localparam int OutW    = 17;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 4;

  // Square root unit: radicand (a^2 + b^2) * 2^16, one root bit a cycle
  localparam int SqW      = 31;
  localparam int SumSqW   = 32;
  localparam int SqrtRadW = 48;
  localparam int RootW    = 24;
  localparam int SqrtCntW = $clog2(RootW);

  // CORDIC datapath and angle in radians Q2.30
  localparam int CordW = 28;
  localparam int AngW  = 32;

  // Shared multiplier and blend datapath
  localparam int MulAW = 34;
  localparam int MulBW = 25;
  localparam int MulPW = 59;
  localparam int TW    = 25;
  localparam int Q0W   = 16;
  localparam int PredW = 34;
  localparam int SumW  = 52;

  // Radians Q2.30 to degrees Q9.8: round(m * DegNum / (DegDiv * 2^30))
  localparam int DegNum   = 4608000;
  localparam int DegDiv   = 314;
  localparam int DegHalf  = 157;
  localparam int DegRecip = 13678239;  // floor(2^32 / 314)
  localparam int SatLimit = 46080;

  // Register indexes and reset values
  localparam logic [CfgIdxW-1:0] RegBlendWeight  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSamplePeriod = CfgIdxW'(1);
  localparam logic [CfgW-1:0]    BlendReset      = 16'd64225;
  localparam logic [CfgW-1:0]    PeriodReset     = 16'd328;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    StIdle,
    StSqA,
    StSqB,
    StRootGo,
    StRootWait,
    StCordGo,
    StCordWait,
    StDeg1,
    StDeg2,
    StDeg3,
    StDeg4,
    StBl1,
    StBl2,
    StBl3,
    StBl4,
    StOut
  } state_e;

  // Truncated atan(2^-i) in radians Q2.30
  function automatic logic signed [AngW-1:0] atan_entry(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcf_mul.sv =====
`default_nettype none

module tcf_mul (
  input  wire                               clk_i,
  input  wire logic signed [tcf_pkg::MulAW-1:0] a_i,
  input  wire logic signed [tcf_pkg::MulBW-1:0] b_i,
  output logic signed [tcf_pkg::MulPW-1:0]      p_o
);
  import tcf_pkg::*;

  logic signed [MulPW-1:0] p_d, p_q;

  // Form the full signed product
  always_comb begin
    p_d = MulPW'(a_i) * MulPW'(b_i);
  end

  // Register the product
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/tcf_isqrt.sv =====
`default_nettype none

module tcf_isqrt (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire logic [tcf_pkg::SqrtRadW-1:0] rad_i,
  output tcf_pkg::unit_sts_t              sts_o,
  output logic [tcf_pkg::RootW-1:0]       root_o
);
  import tcf_pkg::*;

  logic [SqrtRadW-1:0] rad_q, rad_d;
  logic [RootW+1:0]    rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [SqrtCntW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [RootW+1:0]    rem_sh;
  logic [RootW+1:0]    trial;
  logic                last;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q[RootW-1:0], rad_q[SqrtRadW-1 -: 2]};
    trial  = {root_q, 2'b01};
    last   = (cnt_q == SqrtCntW'(RootW - 1));
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SqrtRadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + SqrtCntW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && last;
  assign root_o     = root_q;

endmodule

`default_nettype wire

// ===== rtl/tcf_cordic.sv =====
`default_nettype none

module tcf_cordic (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  input  wire logic [tcf_pkg::RootW-1:0]      x0_i,
  input  wire logic signed [tcf_pkg::CordW-1:0] y0_i,
  output tcf_pkg::unit_sts_t                  sts_o,
  output logic signed [tcf_pkg::AngW-1:0]     z_o
);
  import tcf_pkg::*;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [AngW-1:0]  z_q, z_d, da;
  logic [StepW-1:0]        step_q, step_d;
  logic                    busy_q, busy_d;
  logic                    last;

  // Rotate one step towards y = 0, treating y = 0 as non-positive
  always_comb begin
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    da     = atan_entry(step_q);
    last   = (step_q == StepW'(NumSteps - 1));
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      x_d    = CordW'(x0_i);
      y_d    = y0_i;
      z_d    = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + da;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - da;
      end
      step_d = step_q + StepW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && last;
  assign z_o        = z_q;

endmodule

`default_nettype wire

// ===== rtl/tilt_complementary_filter.sv =====
`default_nettype none
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  accel_x, accel_y, accel_z, pitch_rate, roll_rate
// m_axis    out  m_axis_tvalid/m_axis_tready  pitch_angle, roll_angle
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// A sample runs through both tilts and both blends from acceptance to the
// next acceptance; a tilt with both operands zero skips its root and CORDIC
// passes. The bit-serial root and the one-step-a-cycle CORDIC dominate; a
// single registered multiplier serves squares, degree scaling and blending.
// Reset clears the filter state to zero and loads the register defaults. A
// stalled result holds in the output register while the next sample is
// accepted; that sample finishes and waits for the register.

module tilt_complementary_filter (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32],
  // pitch_rate [63:48], roll_rate [79:64]
  input  wire  logic [79:0]                  s_axis_tdata,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // pitch_angle [16:0], roll_angle [33:17], zero [39:34]
  output logic [39:0]                        m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  logic [tcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  logic [tcf_pkg::CfgW-1:0]     cfg_data_i
);
  import tcf_pkg::*;

  state_e state_q, state_d;
  logic   axis_q, axis_d;

  logic [CfgW-1:0] blend_q, period_q;

  logic signed [InW-1:0]  ax_q, ay_q, az_q, pr_q, rr_q;
  logic [SqW-1:0]         sq_q;
  logic [TW-1:0]          t_q;
  logic [Q0W-1:0]         q0_q;
  logic signed [PredW-1:0] pred_q;
  logic signed [SumW-1:0]  acc_q;
  logic signed [OutW-1:0]  tilt_q [2];
  logic signed [OutW-1:0]  last_q [2];
  logic signed [OutW-1:0]  out_pitch_q, out_roll_q;
  logic                    out_valid_q, out_valid_d;

  logic                    accept, out_load;
  logic                    sqrt_start, cord_start, tilt_zero;
  unit_sts_t               sqrt_sts, cord_sts;
  logic [RootW-1:0]        root;
  logic signed [AngW-1:0]  z;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  logic signed [InW-1:0]   cur_a, cur_n_src, cur_rate;
  logic signed [InW:0]     cur_n;
  logic [SumSqW-1:0]       sum_sq;
  logic                    z_neg;
  logic [AngW-1:0]         z_abs;
  logic [TW-1:0]           t_d, rem;
  logic [Q0W-1:0]          q0_d;
  logic [Q0W:0]            q_mag;
  logic signed [OutW-1:0]  tilt_d, blend_res;
  logic [OutW-1:0]         one_minus;
  logic signed [PredW-1:0] pred_d;
  logic signed [SumW-1:0]  acc_d, sum, shifted;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Pick the operands of the current axis
  always_comb begin
    cur_a     = axis_q ? az_q : ay_q;
    cur_n_src = axis_q ? ay_q : az_q;
    cur_rate  = axis_q ? rr_q : pr_q;
    cur_n     = -(OutW'(cur_n_src));
    sum_sq    = SumSqW'(sq_q) + SumSqW'(prod[SqW-1:0]);
    tilt_zero = (sum_sq == '0) && (cur_n_src == '0);
  end

  // Degree scaling and rounding arithmetic
  always_comb begin
    z_neg  = z[AngW-1];
    z_abs  = z_neg ? AngW'(-z) : AngW'(z);
    t_d    = TW'(prod >>> 30) + TW'(DegHalf);
    q0_d   = prod[32 +: Q0W];
    rem    = t_q - prod[TW-1:0];
    q_mag  = {1'b0, q0_q} + ((rem >= TW'(DegDiv)) ? (Q0W+1)'(1) : '0);
    tilt_d = z_neg ? -$signed(OutW'(q_mag)) : $signed(OutW'(q_mag));
  end

  // Blend arithmetic with saturation
  always_comb begin
    one_minus = OutW'(65536) - OutW'(blend_q);
    pred_d    = (PredW'(last_q[axis_q]) <<< 15) + PredW'(prod);
    acc_d     = SumW'(prod) <<< 15;
    sum       = acc_q + SumW'(prod) + (SumW'(1) <<< 30);
    shifted   = sum >>> 31;
    if (shifted > SatLimit) begin
      blend_res = OutW'(SatLimit);
    end else if (shifted < -SatLimit) begin
      blend_res = -OutW'(SatLimit);
    end else begin
      blend_res = OutW'(shifted);
    end
  end

  // Steer the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSqA: begin
        mul_a = MulAW'(cur_a);
        mul_b = MulBW'(cur_a);
      end
      StSqB: begin
        mul_a = MulAW'(ax_q);
        mul_b = MulBW'(ax_q);
      end
      StDeg1: begin
        mul_a = $signed({2'b00, z_abs});
        mul_b = MulBW'(DegNum);
      end
      StDeg2: begin
        mul_a = $signed({9'd0, t_d});
        mul_b = MulBW'(DegRecip);
      end
      StDeg3: begin
        mul_a = $signed({18'd0, q0_d});
        mul_b = MulBW'(DegDiv);
      end
      StBl1: begin
        mul_a = MulAW'(cur_rate);
        mul_b = $signed({9'd0, period_q});
      end
      StBl2: begin
        mul_a = MulAW'(tilt_q[axis_q]);
        mul_b = $signed({8'd0, one_minus});
      end
      StBl3: begin
        mul_a = pred_q;
        mul_b = $signed({9'd0, blend_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tcf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tcf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({sum_sq, 16'd0}),
    .sts_o   (sqrt_sts),
    .root_o  (root)
  );

  tcf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x0_i    (root),
    .y0_i    (CordW'(cur_n) <<< 8),
    .sts_o   (cord_sts),
    .z_o     (z)
  );

  // Sequence the two tilts, then the two blends
  always_comb begin
    state_d       = state_q;
    axis_d        = axis_q;
    sqrt_start    = 1'b0;
    cord_start    = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = StSqA;
        end
      end
      StSqA:    state_d = StSqB;
      StSqB:    state_d = StRootGo;
      StRootGo: begin
        if (tilt_zero) begin
          axis_d  = !axis_q;
          state_d = axis_q ? StBl1 : StSqA;
        end else begin
          sqrt_start = 1'b1;
          state_d    = StRootWait;
        end
      end
      StRootWait: begin
        if (sqrt_sts.done) begin
          state_d = StCordGo;
        end
      end
      StCordGo: begin
        cord_start = 1'b1;
        state_d    = StCordWait;
      end
      StCordWait: begin
        if (cord_sts.done) begin
          state_d = StDeg1;
        end
      end
      StDeg1:   state_d = StDeg2;
      StDeg2:   state_d = StDeg3;
      StDeg3:   state_d = StDeg4;
      StDeg4: begin
        axis_d  = !axis_q;
        state_d = axis_q ? StBl1 : StSqA;
      end
      StBl1:    state_d = StBl2;
      StBl2:    state_d = StBl3;
      StBl3:    state_d = StBl4;
      StBl4: begin
        axis_d  = !axis_q;
        state_d = axis_q ? StOut : StBl1;
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Take configuration writes; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q  <= BlendReset;
      period_q <= PeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegBlendWeight) begin
        blend_q <= cfg_data_i;
      end else if (cfg_index_i == RegSamplePeriod) begin
        period_q <= cfg_data_i;
      end
    end
  end

  // Hold the filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q[0] <= '0;
      last_q[1] <= '0;
    end else if (state_q == StBl4) begin
      last_q[axis_q] <= blend_res;
    end
  end

  // Capture the request and the working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= s_axis_tdata[15:0];
      ay_q <= s_axis_tdata[31:16];
      az_q <= s_axis_tdata[47:32];
      pr_q <= s_axis_tdata[63:48];
      rr_q <= s_axis_tdata[79:64];
    end
    if (state_q == StSqB) begin
      sq_q <= prod[SqW-1:0];
    end
    if (state_q == StRootGo && tilt_zero) begin
      tilt_q[axis_q] <= '0;
    end
    if (state_q == StDeg2) begin
      t_q <= t_d;
    end
    if (state_q == StDeg3) begin
      q0_q <= q0_d;
    end
    if (state_q == StDeg4) begin
      tilt_q[axis_q] <= tilt_d;
    end
    if (state_q == StBl2) begin
      pred_q <= pred_d;
    end
    if (state_q == StBl3) begin
      acc_q <= acc_d;
    end
    if (out_load) begin
      out_pitch_q <= last_q[0];
      out_roll_q  <= last_q[1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_roll_q, out_pitch_q};

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_sts.busy && cord_sts.busy))
    else $error("root and CORDIC units busy together");

  a_state_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q[0] <= SatLimit) && (last_q[0] >= -SatLimit) &&
    (last_q[1] <= SatLimit) && (last_q[1] >= -SatLimit))
    else $error("filter state outside saturation range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StSqA) && !axis_q)
    else $error("accepted request did not start the pitch tilt");

  a_cordic_to_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_sts.done |=> (state_q == StDeg1))
    else $error("CORDIC result not taken for scaling");
`endif

endmodule

`default_nettype wire

// ===== verif/tilt_complementary_filter_test.sv =====
`timescale 1ns / 1ps

// One sample request, accel_x in the lowest bits
typedef struct packed {
  logic signed [tcf_pkg::InW-1:0] roll_rate;
  logic signed [tcf_pkg::InW-1:0] pitch_rate;
  logic signed [tcf_pkg::InW-1:0] accel_z;
  logic signed [tcf_pkg::InW-1:0] accel_y;
  logic signed [tcf_pkg::InW-1:0] accel_x;
} imu_sample_t;

// One filtered result, pitch in the lowest bits
typedef struct packed {
  logic [5:0]                      pad;
  logic signed [tcf_pkg::OutW-1:0] roll_angle;
  logic signed [tcf_pkg::OutW-1:0] pitch_angle;
} tilt_angles_t;

class angle_checker;
  logic [tcf_pkg::CfgW-1:0] blend_weight;
  logic [tcf_pkg::CfgW-1:0] sample_period;
  longint                   pitch_state;
  longint                   roll_state;
  longint                   atan_q30 [24];
  tilt_angles_t             pending_angles [$];
  int                       mismatches;

  function new();
    blend_weight  = tcf_pkg::BlendReset;
    sample_period = tcf_pkg::PeriodReset;
    pitch_state   = 0;
    roll_state    = 0;
    mismatches    = 0;
    // atan(2^-i) in radians Q2.30, truncated
    atan_q30 = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                 64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
  endfunction

  function void write_reg(logic [tcf_pkg::CfgIdxW-1:0] idx, logic [tcf_pkg::CfgW-1:0] val);
    if (idx == tcf_pkg::RegBlendWeight)
      blend_weight = val;
    else if (idx == tcf_pkg::RegSamplePeriod)
      sample_period = val;
  endfunction

  // Exact integer square root, two radicand bits a pass
  function longint unsigned int_sqrt(longint unsigned radicand);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > radicand)
      probe >>= 2;
    while (probe != 0) begin
      if (radicand >= root + probe) begin
        radicand -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Degrees Q9.8 of atan2(numer, sqrt(a^2 + b^2)) through vectoring CORDIC
  function longint tilt_deg(longint numer, longint a, longint b);
    longint unsigned radicand;
    longint          x, y, z, dx, dy, mag, deg_den;
    radicand = a * a + b * b;
    x        = longint'(int_sqrt(radicand << 16));
    y        = numer * 256;
    z        = 0;
    deg_den  = longint'(tcf_pkg::DegDiv) <<< 30;
    // both operands zero: level
    if (x == 0 && y == 0)
      return 0;
    for (int i = 0; i < tcf_pkg::NumSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += atan_q30[i];
      end else begin
        x -= dx;
        y += dy;
        z -= atan_q30[i];
      end
    end
    // round the magnitude to nearest, ties away from zero
    mag = (z < 0) ? -z : z;
    mag = (mag * tcf_pkg::DegNum + deg_den / 2) / deg_den;
    return (z < 0) ? -mag : mag;
  endfunction

  // alpha * (prev + rate * dt) + (1 - alpha) * tilt, rounded half up, clamped
  function longint blend_step(longint prev, longint rate, longint tilt);
    longint alpha, pred, acc;
    alpha = longint'(blend_weight);
    pred  = prev * 32768 + rate * longint'(sample_period);
    acc   = alpha * pred + (65536 - alpha) * (tilt * 32768);
    acc   = (acc + (64'sd1 <<< 30)) >>> 31;
    if (acc > tcf_pkg::SatLimit)
      acc = tcf_pkg::SatLimit;
    if (acc < -tcf_pkg::SatLimit)
      acc = -tcf_pkg::SatLimit;
    return acc;
  endfunction

  function void note_sample(imu_sample_t smp);
    longint       ax, ay, az;
    tilt_angles_t want;
    ax = smp.accel_x;
    ay = smp.accel_y;
    az = smp.accel_z;
    pitch_state = blend_step(pitch_state, smp.pitch_rate, tilt_deg(-az, ay, ax));
    roll_state  = blend_step(roll_state, smp.roll_rate, tilt_deg(-ay, az, ax));
    want.pad         = '0;
    want.pitch_angle = pitch_state[tcf_pkg::OutW-1:0];
    want.roll_angle  = roll_state[tcf_pkg::OutW-1:0];
    pending_angles.push_back(want);
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%s", msg);
  endfunction

  function void check_angles(tilt_angles_t got);
    tilt_angles_t want;
    if (pending_angles.size() == 0) begin
      report($sformatf("result pitch %0d roll %0d arrived with no sample outstanding",
                       $signed(got.pitch_angle), $signed(got.roll_angle)));
      return;
    end
    want = pending_angles.pop_front();
    if (got.pitch_angle !== want.pitch_angle)
      report($sformatf("pitch_angle: expected %0d, got %0d",
                       $signed(want.pitch_angle), $signed(got.pitch_angle)));
    if (got.roll_angle !== want.roll_angle)
      report($sformatf("roll_angle: expected %0d, got %0d",
                       $signed(want.roll_angle), $signed(got.roll_angle)));
    if (got.pad !== want.pad)
      report($sformatf("result padding: expected %0h, got %0h", want.pad, got.pad));
  endfunction
endclass

module tilt_complementary_filter_test;

  localparam int WatchLimit = 2000;
  localparam int TailCycles = 250;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 135;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic [79:0]                  s_axis_tdata  = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [39:0]                  m_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [tcf_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [tcf_pkg::CfgW-1:0]     cfg_data_i    = '0;

  int           src_idle_pct   = 0;
  int           sink_stall_pct = 0;
  int           quiet_cycles   = 0;
  angle_checker board;

  tilt_complementary_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check each accepted result; end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_angles(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("tilt_complementary_filter verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic imu_sample_t imu(int ax, int ay, int az, int pr, int rr);
    imu_sample_t smp;
    smp.accel_x    = 16'(ax);
    smp.accel_y    = 16'(ay);
    smp.accel_z    = 16'(az);
    smp.pitch_rate = 16'(pr);
    smp.roll_rate  = 16'(rr);
    return smp;
  endfunction

  // Lean on extremes, zero and tiny counts, otherwise full range
  function automatic logic [15:0] pick_count();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one sample request, optionally after an idle gap
  task automatic send_sample(input imu_sample_t smp);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(200, 1)) @(posedge clk_i);
    end
    s_axis_tdata  <= smp;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(smp);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending_angles.size() != 0);
  endtask

  // Write both registers with an unmapped index in between
  task automatic load_config(input logic [15:0] blend, input logic [15:0] period);
    logic [tcf_pkg::CfgIdxW-1:0] idx [3];
    logic [tcf_pkg::CfgW-1:0]    val [3];
    idx[0] = tcf_pkg::RegBlendWeight;
    idx[1] = tcf_pkg::CfgIdxW'($urandom_range(2 ** tcf_pkg::CfgIdxW - 1,
                                              tcf_pkg::RegSamplePeriod + 1));
    idx[2] = tcf_pkg::RegSamplePeriod;
    val[0] = blend;
    val[1] = 16'($urandom);
    val[2] = period;
    for (int k = 0; k < 3; k++) begin
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_reg(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] blend;
    logic [15:0] period;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: level, vertical axes, extremes, tiny counts
    send_sample(imu(0, 0, 0, 0, 0));
    send_sample(imu(0, 0, 16384, 100, -100));
    send_sample(imu(0, 0, -32768, 0, 0));
    send_sample(imu(0, 32767, 0, 0, 0));
    send_sample(imu(0, -32768, 0, 0, 0));
    send_sample(imu(32767, 0, 0, 0, 0));
    send_sample(imu(-32768, -32768, -32768, -32768, -32768));
    send_sample(imu(32767, 32767, 32767, 32767, 32767));
    send_sample(imu(1, -1, 1, 1, -1));
    send_sample(imu(-1, 0, 0, 0, 0));
    send_sample(imu(0, 0, 1, 0, 0));
    send_sample(imu(32767, 32767, -32768, -32768, 32767));

    // Full gyro weight and a long step: drive both angles into saturation
    drain_results();
    load_config(16'hFFFF, 16'hFFFF);
    repeat (4) send_sample(imu(0, 0, 0, 32767, -32768));
    repeat (4) send_sample(imu(0, 0, 0, -32768, 32767));

    // No gyro weight, no step: tilt alone
    drain_results();
    load_config('0, '0);
    send_sample(imu(100, -200, 300, 32767, -32768));
    send_sample(imu(0, 0, 0, 0, 0));

    // Random phases, each with its own settings and idling pattern
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      case ($urandom_range(3))
        0:       blend = '0;
        1:       blend = '1;
        2:       blend = tcf_pkg::BlendReset;
        default: blend = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0:       period = '0;
        1:       period = '1;
        2:       period = tcf_pkg::PeriodReset;
        3:       period = 16'($urandom_range(4000));
        default: period = 16'($urandom);
      endcase
      load_config(blend, period);
      case (phase % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 46;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 46;
        end
        default: begin
          src_idle_pct   = 9;
          sink_stall_pct = 9;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if ((phase == 1 && n == 60) || $urandom_range(199) == 0)
          drain_results();
        send_sample(imu(pick_count(), pick_count(), pick_count(),
                        pick_count(), pick_count()));
      end
    end

    // Let the last results out, then allow for anything spurious
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_angles.size() == 0)
      $display("tilt_complementary_filter verification clean");
    else
      $display("tilt_complementary_filter verification failed");
    $finish;
  end

endmodule
